// ===== design/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants for the touch slider baseline/centroid unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int MAX_PADS_DEF = 8;
  localparam int RAW_BITS_DEF = 22;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int APC_W      = 4;
  localparam int MINPK_W    = 22;
  localparam int STEP_W     = 16;
  localparam int CENTER_W   = 12;
  localparam int INTEN_W    = 24;
  localparam int Q_W        = 9;

  localparam logic [APC_W-1:0]   APC_RST   = 4'd5;
  localparam logic [MINPK_W-1:0] MINPK_RST = 22'd1200;
  localparam logic [STEP_W-1:0]  RISE_RST  = 16'd1;
  localparam logic [STEP_W-1:0]  FALL_RST  = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_PADS = 2'd0,
    REG_MIN_PEAK    = 2'd1,
    REG_RISE_STEP   = 2'd2,
    REG_FALL_STEP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== design/tsb_ram.sv =====
// ----------------------------------------------------------------------------
// tsb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/tsb_div.sv =====
// ----------------------------------------------------------------------------
// tsb_div
// Restoring divider for the interpolation fraction: q = num*256/den, num<=den.
// One quotient bit per cycle; a zero divisor yields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_div #(
  parameter int DW = 26
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tsb_pkg::div_ctl_t      ctl_i,
  output tsb_pkg::div_ctl_t           ctl_o,
  input  wire logic [DW-1:0]          num,
  input  wire logic [DW-1:0]          den,
  output logic      [tsb_pkg::Q_W-1:0] quot
);

  import tsb_pkg::*;

  logic [DW:0]    rem_r, rem_nxt;
  logic [DW-1:0]  den_r;
  logic [Q_W-1:0] q_r, q_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           zero_r;
  logic           done_r, done_nxt;
  logic           ge;
  logic [DW:0]    diff;

  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      rem_nxt = {1'b0, num};
      q_nxt   = '0;
      cnt_nxt = 4'(Q_W);
    end else if (cnt_r != 4'd0) begin
      rem_nxt  = {diff[DW-1:0], 1'b0};
      q_nxt    = {q_r[Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 4'd1;
      done_nxt = (cnt_r == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (ctl_i.start) begin
      den_r  <= den;
      zero_r <= (den == '0);
    end
  end

  assign quot        = zero_r ? '0 : q_r;
  assign ctl_o.done  = done_r;
  assign ctl_o.start = 1'b0;

endmodule

`default_nettype wire

// ===== design/touch_slider_baseline_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// touch_slider_baseline_centroid_unit
// Per-pad baseline tracking and peak/centroid interpolation for a touch slider.
//
// in_*  : one raw pad sample per transfer, pads in scan order. in_tdata holds
//         raw_value, in_tuser holds read_error.
// out_* : one result per scan, sent after the last pad of the scan.
// cfg_* : register writes (pad count, min peak, rise and fall steps); writing
//         the pad count restarts the scan and re-seeds the baselines.
// Samples are taken one per cycle in the idle state, but the last pad of a scan
// waits while a result is still held. After the last pad of a valid scan the
// baseline RAM is swept once, then come a setup step, the divider (nine
// quotient bits plus the done step) and a result step; during all of these no
// sample is taken. An invalid scan skips the sweep, setup and divider steps.
// The sweep reads and writes back one baseline RAM entry per cycle.
// Reset restores register defaults and starts a fresh, unseeded scan.
// A result waits in the output register while the receiver stalls; samples
// keep flowing until the last pad of the next scan, which then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_slider_baseline_centroid_unit #(
  parameter int MAX_PADS = tsb_pkg::MAX_PADS_DEF,
  parameter int RAW_BITS = tsb_pkg::RAW_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // raw_value (RAW_BITS), zero fill
  input  wire logic [((RAW_BITS+7)/8)*8-1:0]     in_tdata,
  // read_error
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // scan_valid, touched, center_position[11:0], intensity[23:0], zero fill
  output logic [39:0]                            out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [tsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tsb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import tsb_pkg::*;

  localparam int IW  = $clog2(MAX_PADS);
  localparam int PCW = $clog2(MAX_PADS + 1);
  localparam int NW  = (PCW > APC_W) ? PCW : APC_W;
  localparam int BLW = RAW_BITS + 10;
  localparam int DLW = RAW_BITS + 2;
  localparam int DW  = RAW_BITS + 4;
  localparam int SW  = (DW > INTEN_W) ? DW : INTEN_W + 1;
  localparam int MW  = (RAW_BITS + 1 > MINPK_W) ? RAW_BITS + 1 : MINPK_W;

  // configuration
  logic [APC_W-1:0]   apc_r;
  logic [MINPK_W-1:0] minpk_r;
  logic [STEP_W-1:0]  rise_r, fall_r;

  state_t state_r, state_nxt;

  logic [IW-1:0]  pad_idx_r, eff_idx;
  logic           scan_bad_r, seeded_r, res_ok_r;
  logic [PCW-1:0] n_pads;
  logic [NW-1:0]  apc_ext;
  logic           last_pad, in_acc, smp_bad;
  logic [RAW_BITS-1:0] raw;

  // sweep
  logic [PCW-1:0] rd_cnt_r;
  logic           rd_issue;
  logic           p_vld_r;
  logic [IW-1:0]  p_idx_r;
  logic           sweep_end;
  logic [RAW_BITS-1:0] smp_q;
  logic [BLW-1:0] bl_q, bl_old, bl_new;
  logic signed [DLW-1:0] norm, delta, val_s;

  // peak tracking
  logic signed [DLW-1:0] peak_r, left_r, right_r, prev_r;
  logic [IW-1:0]  bin_r;
  logic           found_r;

  // interpolation
  logic           dir_r, touch_r;
  logic signed [DLW:0]   num_c;
  logic signed [DLW+1:0] den_c;
  logic [SW-1:0]  sum_c;
  logic [INTEN_W-1:0] inten_r;
  logic [Q_W-1:0] quot;
  div_ctl_t       div_in, div_out;
  logic [CENTER_W-1:0] ctr_base, ctr_c;

  // output register
  logic           out_load;
  logic           out_touch_r;
  logic [CENTER_W-1:0] out_ctr_r;
  logic [INTEN_W-1:0]  out_inten_r;
  logic           out_ok_r;

  assign raw     = in_tdata[RAW_BITS-1:0];
  assign smp_bad = in_tuser || (raw == '0);

  always_comb begin
    apc_ext = NW'(apc_r);
    if (apc_ext == '0) begin
      n_pads = PCW'(1);
    end else if (apc_ext > NW'(MAX_PADS)) begin
      n_pads = PCW'(MAX_PADS);
    end else begin
      n_pads = PCW'(apc_ext);
    end
  end

  assign eff_idx  = (PCW'(pad_idx_r) >= n_pads) ? '0 : pad_idx_r;
  assign last_pad = (PCW'(eff_idx) + PCW'(1)) == n_pads;
  assign in_acc   = in_tvalid && in_tready;

  // ---------------- memories ----------------
  tsb_ram #(.WIDTH(RAW_BITS), .DEPTH(MAX_PADS)) u_smp (
    .clk   (clk),
    .we    (in_acc),
    .waddr (eff_idx),
    .wdata (raw),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (smp_q)
  );

  tsb_ram #(.WIDTH(BLW), .DEPTH(MAX_PADS)) u_bl (
    .clk   (clk),
    .we    (p_vld_r),
    .waddr (p_idx_r),
    .wdata (bl_new),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (bl_q)
  );

  // baseline update, read-modify-write
  assign bl_old = seeded_r ? bl_q : {2'b00, smp_q, 8'h00};
  assign norm   = $signed(bl_old[BLW-1:8]);
  assign val_s  = $signed({2'b00, smp_q});
  assign delta  = val_s - norm;
  assign bl_new = (norm < val_s) ? (bl_old + BLW'(rise_r)) : (bl_old - BLW'(fall_r));

  assign sweep_end = p_vld_r && ((PCW'(p_idx_r) + PCW'(1)) == n_pads);

  // ---------------- interpolation setup ----------------
  always_comb begin
    if (right_r >= left_r) begin
      num_c = (DLW+1)'(right_r) - (DLW+1)'(left_r);
      den_c = (DLW+2)'(num_c) + (DLW+2)'(peak_r) - (DLW+2)'(left_r);
    end else begin
      num_c = (DLW+1)'(left_r) - (DLW+1)'(right_r);
      den_c = (DLW+2)'(num_c) + (DLW+2)'(peak_r) - (DLW+2)'(right_r);
    end
    sum_c = SW'(peak_r[DLW-2:0]) + SW'(num_c[DLW-1:0]);
  end

  assign div_in.start = (state_r == S_PREP);
  assign div_in.done  = 1'b0;

  tsb_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (div_in),
    .ctl_o (div_out),
    .num   (DW'(num_c[DLW-1:0])),
    .den   (DW'(den_c)),
    .quot  (quot)
  );

  assign ctr_base = CENTER_W'({bin_r, 8'h00});
  assign ctr_c    = dir_r ? (ctr_base + CENTER_W'(quot)) : (ctr_base - CENTER_W'(quot));

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && last_pad) begin
          state_nxt = (scan_bad_r || smp_bad) ? S_FIN : S_SWEEP;
        end
      end
      S_SWEEP: if (sweep_end) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   if (div_out.done) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_issue  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = !(last_pad && out_tvalid);
      S_SWEEP: rd_issue  = rd_cnt_r < n_pads;
      S_FIN:   out_load  = !out_tvalid || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      apc_r      <= APC_RST;
      minpk_r    <= MINPK_RST;
      rise_r     <= RISE_RST;
      fall_r     <= FALL_RST;
      pad_idx_r  <= '0;
      scan_bad_r <= 1'b0;
      seeded_r   <= 1'b0;
      p_vld_r    <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_PADS: begin
            apc_r      <= cfg_wdata[APC_W-1:0];
            seeded_r   <= 1'b0;
            pad_idx_r  <= '0;
            scan_bad_r <= 1'b0;
          end
          REG_MIN_PEAK:  minpk_r <= cfg_wdata[MINPK_W-1:0];
          REG_RISE_STEP: rise_r  <= cfg_wdata[STEP_W-1:0];
          REG_FALL_STEP: fall_r  <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (last_pad) begin
          pad_idx_r  <= '0;
          scan_bad_r <= 1'b0;
        end else begin
          pad_idx_r  <= eff_idx + IW'(1);
          scan_bad_r <= scan_bad_r || smp_bad;
        end
      end
      p_vld_r <= rd_issue;
      if (sweep_end) begin
        seeded_r <= 1'b1;
      end
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && last_pad) begin
      res_ok_r <= !(scan_bad_r || smp_bad);
      rd_cnt_r <= '0;
      peak_r   <= '1;
      found_r  <= 1'b0;
      prev_r   <= '0;
      left_r   <= '0;
      right_r  <= '0;
      bin_r    <= '0;
    end
    if (rd_issue) begin
      rd_cnt_r <= rd_cnt_r + PCW'(1);
    end
    p_idx_r <= rd_cnt_r[IW-1:0];
    if (p_vld_r) begin
      prev_r <= delta;
      if (delta > peak_r) begin
        peak_r  <= delta;
        bin_r   <= p_idx_r;
        left_r  <= (p_idx_r == '0) ? '0 : prev_r;
        right_r <= '0;
        found_r <= 1'b1;
      end else if (found_r && (PCW'(p_idx_r) == PCW'(bin_r) + PCW'(1))) begin
        right_r <= delta;
      end
    end
    if (state_r == S_PREP) begin
      dir_r   <= right_r >= left_r;
      touch_r <= found_r && (MW'(peak_r[DLW-2:0]) >= MW'(minpk_r));
      inten_r <= (sum_c[SW-1:INTEN_W] != '0) ? '1 : sum_c[INTEN_W-1:0];
    end
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_touch_r <= res_ok_r && touch_r;
      out_ctr_r   <= (res_ok_r && touch_r) ? ctr_c : '0;
      out_inten_r <= (res_ok_r && touch_r) ? inten_r : '0;
    end
  end

  assign out_tdata = {2'b00, out_inten_r, out_ctr_r, out_touch_r, out_ok_r};

endmodule

`default_nettype wire
